// ----- design/decimal_ascii_formatter_top_assert.svh -----
// Assertion macros used by the decimal ASCII formatter's emitter module.
`ifndef DECIMAL_ASCII_FORMATTER_TOP_ASSERT_SVH
`define DECIMAL_ASCII_FORMATTER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define DAFMT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("decimal formatter check failed");
`define DAFMT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("decimal formatter check failed");
`else
`define DAFMT_ASSERT_SAME(label, ante, cons)
`define DAFMT_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- design/dafmt_pkg.sv -----
// Types and constants shared by the decimal ASCII formatter.
package dafmt_pkg;

  localparam int NUM_DIGITS = 5;
  localparam int VALUE_W    = 16;
  localparam int DIGIT_W    = 4;
  localparam int CHAR_W     = 8;
  localparam int PLACE_W    = 14;
  localparam int MULT_W     = 17;
  localparam int POS_W      = 3;

  localparam logic [CHAR_W-1:0] ASCII_ZERO    = 8'd48;
  localparam logic [CHAR_W-1:0] ASCII_NEWLINE = 8'd10;

  localparam logic [POS_W-1:0] POS_LAST_DIGIT = 3'd4;
  localparam logic [POS_W-1:0] POS_NEWLINE    = 3'd5;

  localparam logic [PLACE_W-1:0] PLACE_VALUE [NUM_DIGITS] =
    '{14'd10000, 14'd1000, 14'd100, 14'd10, 14'd1};

  typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits_t;

  typedef struct packed {
    logic                valid;
    logic [VALUE_W-1:0]  rem;
    digits_t             digits;
  } frame_t;

endpackage

// ----- design/dafmt_cell.sv -----
// One digit cell: extracts the digit of one decimal place and passes the remainder on.
module dafmt_cell import dafmt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [PLACE_W-1:0] place,
  input  frame_t             up,
  output logic               up_take,
  output frame_t             down,
  input  logic               down_take
);

  logic               valid;
  logic [VALUE_W-1:0] rem;
  digits_t            digits;
  logic [DIGIT_W-1:0] digit;
  logic [MULT_W-1:0]  sub;
  logic [MULT_W-1:0]  mult;

  always_comb begin
    digit = '0;
    sub   = '0;
    mult  = '0;
    for (int d = 1; d < 10; d++) begin
      mult = MULT_W'(place) * MULT_W'(d);
      if (MULT_W'(up.rem) >= mult) begin
        digit = DIGIT_W'(d);
        sub   = mult;
      end
    end
  end

  assign up_take = !valid || down_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_take) begin
      valid <= up.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_take && up.valid) begin
      rem    <= VALUE_W'(MULT_W'(up.rem) - sub);
      digits <= {up.digits[NUM_DIGITS-2:0], digit};
    end
  end

  assign down.valid  = valid;
  assign down.rem    = rem;
  assign down.digits = digits;

endmodule

// ----- design/dafmt_emit.sv -----
// Character emitter: skips leading zeros and sends digits and the newline one per word.
module dafmt_emit import dafmt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  frame_t            frame,
  output logic              frame_take,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAR_W-1:0] char_code,
  output logic              last
);

  `include "decimal_ascii_formatter_top_assert.svh"

  logic                busy;
  logic [POS_W-1:0]    pos;
  digits_t             digits;
  logic                out_free;
  logic                load;
  logic [POS_W-1:0]    first;
  logic [DIGIT_W-1:0]  cur_digit;

  assign out_free   = !out_valid || out_ready;
  assign frame_take = !busy || (pos == POS_NEWLINE && out_free);
  assign load       = frame.valid && frame_take;

  always_comb begin
    first = POS_LAST_DIGIT;
    for (int p = NUM_DIGITS - 2; p >= 0; p--) begin
      if (frame.digits[POS_W'(NUM_DIGITS - 1 - p)] != '0) begin
        first = POS_W'(p);
      end
    end
  end

  assign cur_digit = digits[POS_W'(NUM_DIGITS - 1) - pos];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid <= busy;
      end
      if (load) begin
        busy <= 1'b1;
      end else if (out_free && busy && pos == POS_NEWLINE) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && busy) begin
      if (pos == POS_NEWLINE) begin
        char_code <= ASCII_NEWLINE;
        last      <= 1'b1;
      end else begin
        char_code <= ASCII_ZERO + CHAR_W'(cur_digit);
        last      <= 1'b0;
      end
    end
    if (load) begin
      digits <= frame.digits;
      pos    <= first;
    end else if (out_free && busy) begin
      pos <= pos + POS_W'(1);
    end
  end

  `DAFMT_ASSERT_SAME(a_last_is_newline, out_valid && last, char_code == ASCII_NEWLINE)
  `DAFMT_ASSERT_SAME(a_digit_range, out_valid && !last,
    char_code >= ASCII_ZERO && char_code <= ASCII_ZERO + CHAR_W'(9))
  `DAFMT_ASSERT_NEXT(a_zero_start, load && frame.digits == '0, pos == POS_LAST_DIGIT && busy)

endmodule

// ----- design/decimal_ascii_formatter_top.sv -----
// Top level of the decimal ASCII formatter: digit cell chain and character emitter.
//
//   channel | signals                        | direction
//   in      | in_valid, in_ready, value      | one binary word per number
//   out     | out_valid, out_ready, char_code, last | one char per cycle unless stalled
//
// A number passes five digit cells, then the emitter's digit and output registers.
// Each number then sends two to six characters through the output register, newline last.
// A stalled output freezes the emitter; the cells keep filling until the chain is full.
// Reset clears only valid and busy flags; data registers need none.
module decimal_ascii_formatter_top import dafmt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [VALUE_W-1:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CHAR_W-1:0]  char_code,
  output logic               last
);

  frame_t chain [NUM_DIGITS+1];
  logic   take  [NUM_DIGITS+1];

  assign chain[0].valid  = in_valid;
  assign chain[0].rem    = value;
  assign chain[0].digits = '0;
  assign in_ready        = take[0];

  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    dafmt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .place     (PLACE_VALUE[i]),
      .up        (chain[i]),
      .up_take   (take[i]),
      .down      (chain[i+1]),
      .down_take (take[i+1])
    );
  end

  dafmt_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .frame      (chain[NUM_DIGITS]),
    .frame_take (take[NUM_DIGITS]),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .char_code  (char_code),
    .last       (last)
  );

endmodule
